>>> rtl/core/tpkt_pkg.sv
package tpkt_pkg;

  localparam logic [7:0] VersionReset = 8'd3;

  localparam logic [3:0] CodeDt = 4'd15;
  localparam logic [3:0] CodeCr = 4'd14;
  localparam logic [3:0] CodeCc = 4'd13;

  localparam logic [7:0] MinLiDt   = 8'd2;
  localparam logic [7:0] MinLiCrCc = 8'd6;
  localparam logic [15:0] TpktHdrLen = 16'd4;

  typedef enum logic [2:0] {
    PH_TPKT,
    PH_COTP,
    PH_BODY,
    PH_SKIP_FRAME,
    PH_SKIP_STREAM
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_DATA,
    KIND_ERROR
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_VERSION,
    ERR_TPKT_LEN,
    ERR_LI,
    ERR_SHORT_DT,
    ERR_SHORT_CRCC,
    ERR_TRUNCATED
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  tpdu_code;
    logic [15:0] dest_ref;
    logic [15:0] source_ref;
    logic        end_of_transfer;
    logic [7:0]  payload_byte;
    err_e        error_code;
    logic        frame_last;
  } res_t;

endpackage

>>> rtl/core/tpkt_parse.sv
module tpkt_parse (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_data_i,
  input  logic             in_fire_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_end_i,
  output logic             res_valid_o,
  output tpkt_pkg::res_t   res_o
);

  tpkt_pkg::phase_e ph_q, ph_d;
  logic [7:0]  ver_q;
  logic [15:0] pos_q, pos_d;
  logic [15:0] tot_q, tot_d;
  logic [7:0]  li_q, li_d;
  logic [3:0]  tn_q, tn_d;
  logic [15:0] dr_q, dr_d;
  logic [15:0] sr_q, sr_d;
  logic        eot_q, eot_d;

  logic            res_v;
  tpkt_pkg::res_t  res;
  logic            restart;
  logic            do_err;
  logic            do_trunc;
  logic            err_known;
  logic            err_force;
  tpkt_pkg::err_e  err_c;
  logic            at_end;
  logic            err_ends;
  logic            crcc_new;
  logic            crcc_old;
  logic [15:0]     tot_n;

  assign at_end   = ({1'b0, pos_q} + 17'd1) == {1'b0, tot_q};
  assign crcc_old = (tn_q == tpkt_pkg::CodeCr) || (tn_q == tpkt_pkg::CodeCc);
  assign tot_n    = {tot_q[15:8], in_byte_i};

  always_comb begin
    ph_d      = ph_q;
    pos_d     = pos_q;
    tot_d     = tot_q;
    li_d      = li_q;
    tn_d      = tn_q;
    dr_d      = dr_q;
    sr_d      = sr_q;
    eot_d     = eot_q;
    res_v     = 1'b0;
    res       = '0;
    restart   = 1'b0;
    do_err    = 1'b0;
    do_trunc  = 1'b0;
    err_known = 1'b0;
    err_force = 1'b0;
    err_c     = tpkt_pkg::ERR_NONE;
    err_ends  = 1'b0;
    crcc_new  = 1'b0;

    unique case (ph_q)
      tpkt_pkg::PH_SKIP_STREAM: begin
        if (in_end_i) restart = 1'b1;
      end
      tpkt_pkg::PH_TPKT: begin
        if (pos_q == 16'd0 && in_byte_i != ver_q) begin
          do_err = 1'b1;
          err_c  = tpkt_pkg::ERR_VERSION;
        end else if (pos_q == 16'd3) begin
          tot_d = tot_n;
          if (tot_n < tpkt_pkg::TpktHdrLen) begin
            do_err = 1'b1;
            err_c  = tpkt_pkg::ERR_TPKT_LEN;
          end else if (tot_n == tpkt_pkg::TpktHdrLen) begin
            do_err    = 1'b1;
            err_known = 1'b1;
            err_force = 1'b1;
            err_c     = tpkt_pkg::ERR_LI;
          end else if (in_end_i) begin
            do_trunc = 1'b1;
          end else begin
            ph_d  = tpkt_pkg::PH_COTP;
            pos_d = pos_q + 16'd1;
          end
        end else begin
          if (pos_q == 16'd2) tot_d = {in_byte_i, 8'h00};
          if (in_end_i) do_trunc = 1'b1;
          else pos_d = pos_q + 16'd1;
        end
      end
      tpkt_pkg::PH_COTP: begin
        if (pos_q == 16'd4) begin
          li_d = in_byte_i;
          if (in_byte_i == 8'd0 || ({8'h00, in_byte_i} + 16'd5) > tot_q) begin
            do_err    = 1'b1;
            err_known = 1'b1;
            err_c     = tpkt_pkg::ERR_LI;
          end
        end else if (pos_q == 16'd5) begin
          tn_d = in_byte_i[7:4];
          if (in_byte_i[7:4] == tpkt_pkg::CodeDt && li_q < tpkt_pkg::MinLiDt) begin
            do_err    = 1'b1;
            err_known = 1'b1;
            err_c     = tpkt_pkg::ERR_SHORT_DT;
          end else if ((in_byte_i[7:4] == tpkt_pkg::CodeCr ||
                        in_byte_i[7:4] == tpkt_pkg::CodeCc) &&
                       li_q < tpkt_pkg::MinLiCrCc) begin
            do_err    = 1'b1;
            err_known = 1'b1;
            err_c     = tpkt_pkg::ERR_SHORT_CRCC;
          end
        end else if (tn_q == tpkt_pkg::CodeDt) begin
          if (pos_q == 16'd6) eot_d = in_byte_i[7];
        end else if (crcc_old) begin
          if (pos_q == 16'd6 || pos_q == 16'd7) dr_d = {dr_q[7:0], in_byte_i};
          else if (pos_q == 16'd8 || pos_q == 16'd9) sr_d = {sr_q[7:0], in_byte_i};
        end
        crcc_new = (tn_d == tpkt_pkg::CodeCr) || (tn_d == tpkt_pkg::CodeCc);
        if (!do_err) begin
          if (!at_end && in_end_i) begin
            do_trunc = 1'b1;
          end else if (pos_q >= 16'd5 && pos_q == (16'd4 + {8'h00, li_d})) begin
            res_v                = 1'b1;
            res.kind             = tpkt_pkg::KIND_HEADER;
            res.tpdu_code        = tn_d;
            res.dest_ref         = crcc_new ? dr_d : 16'h0000;
            res.source_ref       = crcc_new ? sr_d : 16'h0000;
            res.end_of_transfer  = (tn_d == tpkt_pkg::CodeDt) ? eot_d : 1'b0;
            res.frame_last       = at_end;
            if (at_end) begin
              restart = 1'b1;
            end else begin
              ph_d  = tpkt_pkg::PH_BODY;
              pos_d = pos_q + 16'd1;
            end
          end else begin
            pos_d = pos_q + 16'd1;
          end
        end
      end
      tpkt_pkg::PH_BODY, tpkt_pkg::PH_SKIP_FRAME: begin
        if (!at_end && in_end_i) begin
          do_trunc = 1'b1;
        end else begin
          if (ph_q == tpkt_pkg::PH_BODY && tn_q == tpkt_pkg::CodeDt) begin
            res_v               = 1'b1;
            res.kind            = tpkt_pkg::KIND_DATA;
            res.tpdu_code       = tn_q;
            res.end_of_transfer = eot_q;
            res.payload_byte    = in_byte_i;
            res.frame_last      = at_end;
          end
          if (at_end) restart = 1'b1;
          else pos_d = pos_q + 16'd1;
        end
      end
      default: restart = 1'b1;
    endcase

    if (do_err) begin
      err_ends       = in_end_i || err_force || (err_known && at_end);
      res_v          = 1'b1;
      res            = '0;
      res.kind       = tpkt_pkg::KIND_ERROR;
      res.error_code = err_c;
      res.frame_last = err_ends;
      if (err_ends) begin
        restart = 1'b1;
      end else begin
        ph_d  = err_known ? tpkt_pkg::PH_SKIP_FRAME : tpkt_pkg::PH_SKIP_STREAM;
        pos_d = pos_q + 16'd1;
      end
    end

    if (do_trunc) begin
      res_v          = 1'b1;
      res            = '0;
      res.kind       = tpkt_pkg::KIND_ERROR;
      res.error_code = tpkt_pkg::ERR_TRUNCATED;
      res.frame_last = 1'b1;
      restart        = 1'b1;
    end

    if (restart) begin
      ph_d  = tpkt_pkg::PH_TPKT;
      pos_d = '0;
      tot_d = '0;
      li_d  = '0;
      tn_d  = '0;
      dr_d  = '0;
      sr_d  = '0;
      eot_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= tpkt_pkg::PH_TPKT;
      ver_q <= tpkt_pkg::VersionReset;
      pos_q <= '0;
      tot_q <= '0;
      li_q  <= '0;
      tn_q  <= '0;
      dr_q  <= '0;
      sr_q  <= '0;
      eot_q <= 1'b0;
    end else begin
      if (cfg_we_i) ver_q <= cfg_data_i;
      if (in_fire_i) begin
        ph_q  <= ph_d;
        pos_q <= pos_d;
        tot_q <= tot_d;
        li_q  <= li_d;
        tn_q  <= tn_d;
        dr_q  <= dr_d;
        sr_q  <= sr_d;
        eot_q <= eot_d;
      end
    end
  end

  assign res_valid_o = in_fire_i && res_v;
  assign res_o       = res;

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && in_end_i |=> ph_q == tpkt_pkg::PH_TPKT && pos_q == 16'd0)
    else $error("stream end did not return to TPKT header");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.frame_last |=> ph_q == tpkt_pkg::PH_TPKT && pos_q == 16'd0)
    else $error("frame_last result did not restart frame");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ((res_o.kind == tpkt_pkg::KIND_ERROR) ==
                     (res_o.error_code != tpkt_pkg::ERR_NONE)))
    else $error("error code and result kind disagree");

endmodule

>>> rtl/core/tpkt_out_skid.sv
module tpkt_out_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tpkt_pkg::res_t   push_data_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tpkt_pkg::res_t   out_data_o
);

  logic           out_valid_q;
  logic           skid_valid_q;
  tpkt_pkg::res_t out_q;
  tpkt_pkg::res_t skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && !out_ready_i) begin
      if (push_i) skid_valid_q <= 1'b1;
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && !out_ready_i) begin
      if (push_i) skid_q <= push_data_i;
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (push_i) begin
      out_q <= push_data_i;
    end
  end

  assign room_o      = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_ready_i |=> out_valid_q && !skid_valid_q)
    else $error("skid entry not moved to output register");

endmodule

>>> rtl/core/tpkt_cotp_frame_parser.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: data_byte; tlast: stream_end
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: header/data/error fields;
//                                             tuser: result_kind; tlast: frame_last
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_data_i: required version byte
//
// One byte is accepted per cycle while s_axis_tready is high; its result, if any, is registered for m_axis.
// Parse state advances in one pass from the accepted byte to the output register.
// An output register plus one skid entry absorb one result while m_axis stalls;
// s_axis_tready is low only while the skid entry is occupied.
// Reset returns to the TPKT header phase with the required version byte at 3.
module tpkt_cotp_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] tpdu_code, [19:4] dest_ref, [35:20] source_ref, [36] end_of_transfer,
  // [44:37] payload_byte, [47:45] error_code
  output logic [47:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic           in_fire;
  logic           room;
  logic           res_valid;
  tpkt_pkg::res_t res;
  tpkt_pkg::res_t out;

  assign s_axis_tready = room;
  assign in_fire       = s_axis_tvalid && room;
  assign cfg_ready_o   = 1'b1;

  tpkt_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_fire_i   (in_fire),
    .in_byte_i   (s_axis_tdata),
    .in_end_i    (s_axis_tlast),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tpkt_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out)
  );

  assign m_axis_tdata = {out.error_code, out.payload_byte, out.end_of_transfer,
                         out.source_ref, out.dest_ref, out.tpdu_code};
  assign m_axis_tuser = out.kind;
  assign m_axis_tlast = out.frame_last;

endmodule

>>> verif/tpkt_cotp_frame_parser_tb.sv
module tpkt_cotp_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t[$];

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 8;
  localparam int PhaseBytes  = 150;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;

  tpkt_cotp_frame_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // parser state
  logic [7:0]       version_reg = tpkt_pkg::VersionReset;
  tpkt_pkg::phase_e parse_phase = tpkt_pkg::PH_TPKT;
  logic [15:0]      frame_pos   = '0;
  logic [15:0]      frame_len   = '0;
  logic [7:0]       cotp_li     = '0;
  logic [3:0]       tpdu_nibble = '0;
  logic [15:0]      dest_hold   = '0;
  logic [15:0]      src_hold    = '0;
  logic             eot_flag    = 1'b0;

  tpkt_pkg::res_t pending_results[$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   bytes_sent = 0;
  int   sink_hold = 0;
  bit   src_gaps_on = 1'b1;
  bit   sink_gaps_on = 1'b1;

  task automatic restart_frame();
    parse_phase = tpkt_pkg::PH_TPKT;
    frame_pos   = '0;
    frame_len   = '0;
    cotp_li     = '0;
    tpdu_nibble = '0;
    dest_hold   = '0;
    src_hold    = '0;
    eot_flag    = 1'b0;
  endtask

  task automatic push_error(input tpkt_pkg::err_e code, input logic last);
    tpkt_pkg::res_t r;
    r = '0;
    r.kind = tpkt_pkg::KIND_ERROR;
    r.error_code = code;
    r.frame_last = last;
    pending_results.push_back(r);
  endtask

  task automatic truncate_frame();
    push_error(tpkt_pkg::ERR_TRUNCATED, 1'b1);
    restart_frame();
  endtask

  task automatic fail_frame(input tpkt_pkg::err_e code, input bit known, input logic se);
    logic ends;
    ends = se || (known && int'(frame_pos) + 1 == int'(frame_len));
    push_error(code, ends);
    if (ends) begin
      restart_frame();
    end else begin
      parse_phase = known ? tpkt_pkg::PH_SKIP_FRAME : tpkt_pkg::PH_SKIP_STREAM;
      frame_pos = frame_pos + 16'd1;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic se);
    tpkt_pkg::res_t r;
    logic [15:0] p;
    logic fin;
    bit is_dt;
    bit is_crcc;
    bit done;
    p = frame_pos;
    fin = (int'(p) + 1 == int'(frame_len));
    done = 1'b0;
    r = '0;
    case (parse_phase)
      tpkt_pkg::PH_SKIP_STREAM: begin
        if (se) restart_frame();
      end
      tpkt_pkg::PH_TPKT: begin
        if (p == 0 && b != version_reg) begin
          fail_frame(tpkt_pkg::ERR_VERSION, 1'b0, se);
        end else if (p == 3) begin
          frame_len = {frame_len[15:8], b};
          if (frame_len < tpkt_pkg::TpktHdrLen) begin
            fail_frame(tpkt_pkg::ERR_TPKT_LEN, 1'b0, se);
          end else if (frame_len == tpkt_pkg::TpktHdrLen) begin
            fail_frame(tpkt_pkg::ERR_LI, 1'b1, 1'b1);
          end else if (se) begin
            truncate_frame();
          end else begin
            parse_phase = tpkt_pkg::PH_COTP;
            frame_pos = p + 16'd1;
          end
        end else begin
          if (p == 2) frame_len = {b, 8'h00};
          if (se) truncate_frame();
          else frame_pos = p + 16'd1;
        end
      end
      tpkt_pkg::PH_COTP: begin
        if (p == 4) begin
          cotp_li = b;
          if (b == 0 || int'(b) + 5 > int'(frame_len)) begin
            fail_frame(tpkt_pkg::ERR_LI, 1'b1, se);
            done = 1'b1;
          end
        end else if (p == 5) begin
          tpdu_nibble = b[7:4];
          if (tpdu_nibble == tpkt_pkg::CodeDt && cotp_li < tpkt_pkg::MinLiDt) begin
            fail_frame(tpkt_pkg::ERR_SHORT_DT, 1'b1, se);
            done = 1'b1;
          end else if ((tpdu_nibble == tpkt_pkg::CodeCr ||
                        tpdu_nibble == tpkt_pkg::CodeCc) &&
                       cotp_li < tpkt_pkg::MinLiCrCc) begin
            fail_frame(tpkt_pkg::ERR_SHORT_CRCC, 1'b1, se);
            done = 1'b1;
          end
        end else if (tpdu_nibble == tpkt_pkg::CodeDt) begin
          if (p == 6) eot_flag = b[7];
        end else if (tpdu_nibble == tpkt_pkg::CodeCr || tpdu_nibble == tpkt_pkg::CodeCc) begin
          if (p == 6 || p == 7) dest_hold = {dest_hold[7:0], b};
          else if (p == 8 || p == 9) src_hold = {src_hold[7:0], b};
        end
        if (!done) begin
          is_dt = (tpdu_nibble == tpkt_pkg::CodeDt);
          is_crcc = (tpdu_nibble == tpkt_pkg::CodeCr || tpdu_nibble == tpkt_pkg::CodeCc);
          if (!fin && se) begin
            truncate_frame();
          end else if (p >= 5 && int'(p) == 4 + int'(cotp_li)) begin
            r.kind = tpkt_pkg::KIND_HEADER;
            r.tpdu_code = tpdu_nibble;
            r.dest_ref = is_crcc ? dest_hold : 16'd0;
            r.source_ref = is_crcc ? src_hold : 16'd0;
            r.end_of_transfer = is_dt ? eot_flag : 1'b0;
            r.error_code = tpkt_pkg::ERR_NONE;
            r.frame_last = fin;
            pending_results.push_back(r);
            if (fin) begin
              restart_frame();
            end else begin
              parse_phase = tpkt_pkg::PH_BODY;
              frame_pos = p + 16'd1;
            end
          end else begin
            frame_pos = p + 16'd1;
          end
        end
      end
      tpkt_pkg::PH_BODY, tpkt_pkg::PH_SKIP_FRAME: begin
        if (!fin && se) begin
          truncate_frame();
        end else begin
          if (parse_phase == tpkt_pkg::PH_BODY && tpdu_nibble == tpkt_pkg::CodeDt) begin
            r.kind = tpkt_pkg::KIND_DATA;
            r.tpdu_code = tpdu_nibble;
            r.end_of_transfer = eot_flag;
            r.payload_byte = b;
            r.error_code = tpkt_pkg::ERR_NONE;
            r.frame_last = fin;
            pending_results.push_back(r);
          end
          if (fin) restart_frame();
          else frame_pos = p + 16'd1;
        end
      end
      default: restart_frame();
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic se);
    if (src_gaps_on) begin
      while ($urandom_range(99) < 26) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= se;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_byte(b, se);
    bytes_sent++;
  endtask

  task automatic send_bytes(input byte_q_t q, input int end_at);
    foreach (q[i]) send_byte(q[i], i == end_at);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_version(input logic [7:0] v);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    version_reg = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_frame(input bit clean);
    byte_q_t q;
    int sel;
    int pick;
    int li;
    int body;
    int total;
    int end_at;
    int n;
    logic [3:0] code;
    // resync to a TPKT header
    if (parse_phase != tpkt_pkg::PH_TPKT || frame_pos != 0) send_byte(8'($urandom), 1'b1);
    sel = clean ? 50 : $urandom_range(99);
    if (sel < 8) begin
      n = $urandom_range(1, 12);
      repeat (n) q.push_back(8'($urandom));
      send_bytes(q, $urandom_range(1) ? n - 1 : -1);
    end else begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        code = tpkt_pkg::CodeDt;
        li = $urandom_range(2, 6);
      end else if (pick < 60) begin
        code = tpkt_pkg::CodeCr;
        li = $urandom_range(6, 12);
      end else if (pick < 75) begin
        code = tpkt_pkg::CodeCc;
        li = $urandom_range(6, 12);
      end else begin
        code = 4'($urandom_range(0, 12));
        li = $urandom_range(1, 6);
      end
      body = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      total = 5 + li + body;
      q = '{version_reg, 8'($urandom), total[15:8], total[7:0], 8'(li),
            {code, 4'($urandom)}};
      repeat (li - 1 + body) q.push_back(8'($urandom));
      end_at = $urandom_range(1) ? q.size() - 1 : -1;
      if (sel >= 80) begin
        case ($urandom_range(7))
          0: q[0] = version_reg ^ 8'($urandom_range(1, 255));
          1: begin
            q[2] = 8'h00;
            q[3] = 8'($urandom_range(3));
          end
          2: begin
            q[2] = 8'h00;
            q[3] = 8'h04;
          end
          3: q[4] = 8'h00;
          4: q[4] = 8'((total - 4 + $urandom_range(20)) > 255 ? 255 :
                       total - 4 + $urandom_range(20));
          5: begin
            q[4] = 8'd1;
            q[5] = {tpkt_pkg::CodeDt, 4'($urandom)};
          end
          6: begin
            q[4] = 8'($urandom_range(1, 5));
            q[5] = {$urandom_range(1) ? tpkt_pkg::CodeCr : tpkt_pkg::CodeCc,
                    4'($urandom)};
          end
          default: end_at = $urandom_range(0, q.size() - 2);
        endcase
      end
      send_bytes(q, end_at);
    end
  endtask

  task automatic test_good_frames();
    byte_q_t q;
    q = '{8'h03, 8'h00, 8'h00, 8'h09, 8'h02, 8'hF0, 8'h80, 8'h00, 8'hFF};
    send_bytes(q, 8);
    q = '{8'h03, 8'hA5, 8'h00, 8'h0D, 8'h08, 8'hE0, 8'hFF, 8'hFF, 8'h00, 8'h00,
          8'h00, 8'hC1, 8'h01};
    send_bytes(q, -1);
    q = '{8'h03, 8'h00, 8'h00, 8'h0B, 8'h06, 8'hD0, 8'h12, 8'h34, 8'h56, 8'h78, 8'h00};
    send_bytes(q, -1);
    q = '{8'h03, 8'h00, 8'h00, 8'h09, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h7F};
    send_bytes(q, 8);
    q = '{8'h03, 8'h00, 8'h00, 8'h0A, 8'h03, 8'hF7, 8'h7F, 8'hEE, 8'h01, 8'h80};
    send_bytes(q, -1);
  endtask

  task automatic test_format_errors();
    byte_q_t q;
    q = '{8'h04, 8'h01, 8'h02, 8'h55};
    send_bytes(q, 3);
    q = '{8'h03, 8'h00, 8'h00, 8'h03, 8'h11, 8'h22};
    send_bytes(q, 5);
    q = '{8'h03, 8'h00, 8'h00, 8'h04};
    send_bytes(q, -1);
    q = '{8'h03, 8'h00, 8'h00, 8'h07, 8'h00, 8'hF0, 8'h01};
    send_bytes(q, -1);
    q = '{8'h03, 8'h00, 8'h00, 8'h06, 8'h02, 8'hF0};
    send_bytes(q, -1);
    q = '{8'h03, 8'h00, 8'h00, 8'h08, 8'hFF, 8'hF0, 8'h00, 8'h00};
    send_bytes(q, -1);
    q = '{8'h03, 8'h00, 8'h00, 8'h06, 8'h01, 8'hF0};
    send_bytes(q, -1);
    q = '{8'h03, 8'h00, 8'h00, 8'h0A, 8'h05, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00};
    send_bytes(q, -1);
    q = '{8'h03, 8'h00, 8'h00, 8'h0A, 8'h00, 8'hD0, 8'h00, 8'h00, 8'h00, 8'h00};
    send_bytes(q, -1);
  endtask

  task automatic test_truncation();
    byte_q_t q;
    q = '{8'h03, 8'h00, 8'h00};
    send_bytes(q, 2);
    q = '{8'h03, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hF0, 8'h80, 8'h01};
    send_bytes(q, 7);
    q = '{8'h03, 8'h00, 8'h00, 8'h0C, 8'h02, 8'hF0, 8'h00, 8'h10, 8'h20};
    send_bytes(q, 8);
    q = '{8'h03, 8'h00, 8'h00, 8'h0C, 8'h00, 8'hF0, 8'h00};
    send_bytes(q, 5);
    q = '{8'h03, 8'h00, 8'h00, 8'h0C, 8'h01, 8'hF0};
    send_bytes(q, 5);
    q = '{8'h03, 8'h00, 8'h00, 8'h05};
    send_bytes(q, 3);
    q = '{8'h00};
    send_bytes(q, 0);
  endtask

  task automatic test_version_extremes();
    byte_q_t q;
    set_version(8'h00);
    repeat (3) send_random_frame(1'b1);
    q = '{8'hFF, 8'h00, 8'h00, 8'h09, 8'h02};
    send_bytes(q, 4);
    set_version(8'hFF);
    repeat (3) send_random_frame(1'b1);
    q = '{8'h03, 8'h01};
    send_bytes(q, 1);
    send_random_frame(1'b1);
    set_version(tpkt_pkg::VersionReset);
  endtask

  task automatic test_backpressure();
    byte_q_t q;
    src_gaps_on = 1'b0;
    sink_hold = 120;
    repeat (3) send_random_frame(1'b1);
    q = '{8'h03, 8'h00, 8'h00, 8'h2F, 8'h02, 8'hF0, 8'h00};
    send_bytes(q, -1);
    repeat (39) send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b1);
    // hold off until every result is back
    wait_idle();
    src_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [7:0] versions[4];
    int start;
    versions = '{8'($urandom), 8'h00, 8'hFF, tpkt_pkg::VersionReset};
    foreach (versions[k]) begin
      set_version(versions[k]);
      src_gaps_on = (k != 1);
      sink_gaps_on = (k != 1);
      start = bytes_sent;
      while (bytes_sent - start < PhaseBytes) send_random_frame(1'b0);
    end
    src_gaps_on = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold--;
    end else begin
      m_axis_tready <= !sink_gaps_on || $urandom_range(99) >= 26;
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    tpkt_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction, kind %0d", m_axis_tuser);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", int'(want.kind), int'(m_axis_tuser));
        check_field("tpdu_code", int'(want.tpdu_code), int'(m_axis_tdata[3:0]));
        check_field("dest_ref", int'(want.dest_ref), int'(m_axis_tdata[19:4]));
        check_field("source_ref", int'(want.source_ref), int'(m_axis_tdata[35:20]));
        check_field("end_of_transfer", int'(want.end_of_transfer),
                    int'(m_axis_tdata[36]));
        check_field("payload_byte", int'(want.payload_byte), int'(m_axis_tdata[44:37]));
        check_field("error_code", int'(want.error_code), int'(m_axis_tdata[47:45]));
        check_field("frame_last", int'(want.frame_last), int'(m_axis_tlast));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_good_frames();
    test_format_errors();
    test_truncation();
    test_version_extremes();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> tpkt_cotp_frame_parser.f
rtl/core/tpkt_pkg.sv
rtl/core/tpkt_parse.sv
rtl/core/tpkt_out_skid.sv
rtl/core/tpkt_cotp_frame_parser.sv
verif/tpkt_cotp_frame_parser_tb.sv
